// ----- rtl/core/lkvt_pkg.sv -----
// Package for the linear key/value table: sizes, codes and the microcode ROM.
package lkvt_pkg;

  // Table geometry
  localparam int unsigned Depth = 16;
  localparam int unsigned IdxW  = $clog2(Depth);
  localparam int unsigned CntW  = $clog2(Depth + 1);
  localparam int unsigned KeyW  = 32;
  localparam int unsigned ValW  = 32;
  localparam int unsigned StepW = 5;

  // Operation codes carried in the input tuser
  typedef enum logic [1:0] {
    OpAppend = 2'd0,
    OpFind   = 2'd1,
    OpUpdate = 2'd2,
    OpDelete = 2'd3
  } opcode_e;

  // Result status carried in the output tuser
  typedef enum logic [1:0] {
    StOk      = 2'd0,
    StMissing = 2'd1,
    StFull    = 2'd2
  } status_e;

  // Jump conditions; a true condition loads the target, else the step counter advances
  typedef enum logic [3:0] {
    CondNever   = 4'd0,
    CondAlways  = 4'd1,
    CondNoIn    = 4'd2,
    CondNotApp  = 4'd3,
    CondFull    = 4'd4,
    CondIdxEnd  = 4'd5,
    CondHit     = 4'd6,
    CondFind    = 4'd7,
    CondDel     = 4'd8,
    CondLast    = 4'd9,
    CondOutBusy = 4'd10
  } cond_e;

  // Program step addresses
  localparam logic [StepW-1:0] StepFetch   = 5'd0;
  localparam logic [StepW-1:0] StepDisp    = 5'd1;
  localparam logic [StepW-1:0] StepAppChk  = 5'd2;
  localparam logic [StepW-1:0] StepAppWr   = 5'd3;
  localparam logic [StepW-1:0] StepScan    = 5'd4;
  localparam logic [StepW-1:0] StepTest    = 5'd5;
  localparam logic [StepW-1:0] StepNext    = 5'd6;
  localparam logic [StepW-1:0] StepHit     = 5'd7;
  localparam logic [StepW-1:0] StepHitDel  = 5'd8;
  localparam logic [StepW-1:0] StepUpd     = 5'd9;
  localparam logic [StepW-1:0] StepFindRes = 5'd10;
  localparam logic [StepW-1:0] StepDelChk  = 5'd11;
  localparam logic [StepW-1:0] StepShift   = 5'd12;
  localparam logic [StepW-1:0] StepDelEnd  = 5'd13;
  localparam logic [StepW-1:0] StepMiss    = 5'd14;
  localparam logic [StepW-1:0] StepFullSt  = 5'd15;
  // Last address: falling through wraps the counter back to fetch
  localparam logic [StepW-1:0] StepEmit    = 5'd31;

  // One control word per step
  typedef struct packed {
    cond_e            cond;
    logic [StepW-1:0] target;
    logic             latch;    // capture the input word (gated by accept)
    logic             clr_idx;
    logic             inc_idx;
    logic             wr_app;   // write key/value at the tail
    logic             wr_val;   // overwrite value at idx
    logic             shift;    // copy entry idx+1 down to idx
    logic             ld_res;   // load found value from idx
    logic             inc_cnt;
    logic             dec_cnt;
    logic             set_st;
    status_e          st;
    logic             out_load; // hand result to output register (gated by free)
  } ctrl_word_t;

  // Microcode ROM
  function automatic ctrl_word_t ucode_rom(input logic [StepW-1:0] step);
    ctrl_word_t w;
    w        = '0;
    w.cond   = CondAlways;
    w.target = StepFetch;
    w.st     = StOk;
    unique case (step)
      StepFetch: begin
        w.cond = CondNoIn; w.target = StepFetch; w.latch = 1'b1; w.clr_idx = 1'b1;
      end
      StepDisp: begin
        w.cond = CondNotApp; w.target = StepScan;
      end
      StepAppChk: begin
        w.cond = CondFull; w.target = StepFullSt;
      end
      StepAppWr: begin
        w.target = StepEmit; w.wr_app = 1'b1; w.inc_cnt = 1'b1; w.set_st = 1'b1;
      end
      StepScan: begin
        w.cond = CondIdxEnd; w.target = StepMiss;
      end
      StepTest: begin
        w.cond = CondHit; w.target = StepHit;
      end
      StepNext: begin
        w.target = StepScan; w.inc_idx = 1'b1;
      end
      StepHit: begin
        w.cond = CondFind; w.target = StepFindRes;
      end
      StepHitDel: begin
        w.cond = CondDel; w.target = StepDelChk;
      end
      StepUpd: begin
        w.target = StepEmit; w.wr_val = 1'b1; w.set_st = 1'b1;
      end
      StepFindRes: begin
        w.target = StepEmit; w.ld_res = 1'b1; w.set_st = 1'b1;
      end
      StepDelChk: begin
        w.cond = CondLast; w.target = StepDelEnd;
      end
      StepShift: begin
        w.target = StepDelChk; w.shift = 1'b1; w.inc_idx = 1'b1;
      end
      StepDelEnd: begin
        w.target = StepEmit; w.dec_cnt = 1'b1; w.set_st = 1'b1;
      end
      StepMiss: begin
        w.target = StepEmit; w.set_st = 1'b1; w.st = StMissing;
      end
      StepFullSt: begin
        w.target = StepEmit; w.set_st = 1'b1; w.st = StFull;
      end
      StepEmit: begin
        w.cond = CondOutBusy; w.target = StepEmit; w.out_load = 1'b1;
      end
      default: begin
        w.target = StepFetch;
      end
    endcase
    return w;
  endfunction

endpackage

// ----- rtl/core/linear_key_value_table.sv -----
// Top level of the linear key/value table: microcoded sequencer and its datapath.
//
// Input words arrive on s_axis: tuser carries the operation (append, find,
// update, delete), tdata the key and the value. Each word gives exactly one
// result word on m_axis: tuser is the status (ok, not found, full), tdata
// the found value (zero unless a find hits).
// One word is worked on at a time; s_axis_tready_o is high only in the fetch step.
// An append checks for room and writes at the tail; find, update and delete scan
// from entry zero for the first matching key, and a delete moves each later entry
// down by one. The scan loop reads one entry per pass through three control steps.
// The sequencer returns to fetch in the same cycle as the result turns valid.
// A result waits in the output register while the next word is worked on; a
// stalled receiver holds the sequencer in its emit step until the older result leaves.
// Reset empties the table (entry count zero), clears the output valid flag and
// sends the sequencer to fetch; the key and value stores need no clearing pass.
module linear_key_value_table (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [63:0] s_axis_tdata_i,  // [31:0] key, [63:32] value
  input  logic [1:0]  s_axis_tuser_i,  // [1:0] func
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [31:0] m_axis_tdata_o,  // [31:0] found_value
  output logic [1:0]  m_axis_tuser_o   // [1:0] status
);

  // Stores, no reset: only entries below the count are ever read
  logic [lkvt_pkg::KeyW-1:0] key_store_q [lkvt_pkg::Depth];
  logic [lkvt_pkg::ValW-1:0] val_store_q [lkvt_pkg::Depth];

  logic [lkvt_pkg::StepW-1:0] upc_q, upc_d;
  logic [lkvt_pkg::CntW-1:0]  cnt_q, cnt_d;
  logic [lkvt_pkg::CntW-1:0]  idx_q, idx_d;
  logic [lkvt_pkg::CntW-1:0]  idx_inc;
  logic [lkvt_pkg::IdxW-1:0]  rd_idx, nxt_idx, tail_idx;

  lkvt_pkg::opcode_e          op_q;
  logic [lkvt_pkg::KeyW-1:0]  key_q;
  logic [lkvt_pkg::ValW-1:0]  val_q;
  lkvt_pkg::status_e          st_q;
  logic [lkvt_pkg::ValW-1:0]  res_q;

  logic                       out_valid_q, out_valid_d;
  lkvt_pkg::status_e          out_st_q;
  logic [lkvt_pkg::ValW-1:0]  out_val_q;

  lkvt_pkg::ctrl_word_t       cw;
  logic                       s_accept, out_free, cond_true, key_hit;

  // Control word of the current step
  assign cw = lkvt_pkg::ucode_rom(upc_q);

  assign s_axis_tready_o = (upc_q == lkvt_pkg::StepFetch);
  assign s_accept        = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free        = !out_valid_q || m_axis_tready_i;

  // Index arithmetic
  assign idx_inc  = idx_q + lkvt_pkg::CntW'(1);
  assign rd_idx   = idx_q[lkvt_pkg::IdxW-1:0];
  assign nxt_idx  = idx_inc[lkvt_pkg::IdxW-1:0];
  assign tail_idx = cnt_q[lkvt_pkg::IdxW-1:0];
  assign key_hit  = (key_store_q[rd_idx] == key_q);

  // Condition select
  always_comb begin
    unique case (cw.cond)
      lkvt_pkg::CondNever:   cond_true = 1'b0;
      lkvt_pkg::CondAlways:  cond_true = 1'b1;
      lkvt_pkg::CondNoIn:    cond_true = !s_axis_tvalid_i;
      lkvt_pkg::CondNotApp:  cond_true = (op_q != lkvt_pkg::OpAppend);
      lkvt_pkg::CondFull:    cond_true = (cnt_q >= lkvt_pkg::CntW'(lkvt_pkg::Depth));
      lkvt_pkg::CondIdxEnd:  cond_true = (idx_q >= cnt_q);
      lkvt_pkg::CondHit:     cond_true = key_hit;
      lkvt_pkg::CondFind:    cond_true = (op_q == lkvt_pkg::OpFind);
      lkvt_pkg::CondDel:     cond_true = (op_q == lkvt_pkg::OpDelete);
      lkvt_pkg::CondLast:    cond_true = (idx_inc >= cnt_q);
      lkvt_pkg::CondOutBusy: cond_true = !out_free;
      default:               cond_true = 1'b0;
    endcase
  end

  // Sequencer, counters and output flag
  always_comb begin
    upc_d = cond_true ? cw.target : upc_q + lkvt_pkg::StepW'(1);

    idx_d = idx_q;
    if (cw.clr_idx) begin
      idx_d = '0;
    end else if (cw.inc_idx) begin
      idx_d = idx_inc;
    end

    cnt_d = cnt_q;
    if (cw.inc_cnt) begin
      cnt_d = cnt_q + lkvt_pkg::CntW'(1);
    end else if (cw.dec_cnt) begin
      cnt_d = cnt_q - lkvt_pkg::CntW'(1);
    end

    out_valid_d = out_valid_q && !m_axis_tready_i;
    if (cw.out_load && out_free) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upc_q       <= lkvt_pkg::StepFetch;
      idx_q       <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      upc_q       <= upc_d;
      idx_q       <= idx_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Datapath registers: input word, status, result
  always_ff @(posedge clk_i) begin
    if (cw.latch && s_accept) begin
      op_q  <= lkvt_pkg::opcode_e'(s_axis_tuser_i);
      key_q <= s_axis_tdata_i[31:0];
      val_q <= s_axis_tdata_i[63:32];
      res_q <= '0;
    end else if (cw.ld_res) begin
      res_q <= val_store_q[rd_idx];
    end
    if (cw.set_st) begin
      st_q <= cw.st;
    end
    if (cw.out_load && out_free) begin
      out_st_q  <= st_q;
      out_val_q <= res_q;
    end
  end

  // Store writes: tail append, value overwrite, or move-down on delete
  always_ff @(posedge clk_i) begin
    if (cw.wr_app) begin
      key_store_q[tail_idx] <= key_q;
      val_store_q[tail_idx] <= val_q;
    end else if (cw.wr_val) begin
      val_store_q[rd_idx] <= val_q;
    end else if (cw.shift) begin
      key_store_q[rd_idx] <= key_store_q[nxt_idx];
      val_store_q[rd_idx] <= val_store_q[nxt_idx];
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_val_q;
  assign m_axis_tuser_o  = out_st_q;

endmodule

// ----- verif/linear_key_value_table_tb.sv -----
// Testbench for the linear key/value table: directed and random table operations.
module linear_key_value_table_tb;
  timeunit 1ns;
  timeprecision 1ps;

  // Operation mix per random phase, in percent; delete takes the rest
  localparam int unsigned NumPhases = 7;
  localparam int unsigned PhaseLen  = 100;
  localparam int unsigned AppPct  [NumPhases] = '{25, 60, 25, 10, 60, 15, 10};
  localparam int unsigned FindPct [NumPhases] = '{25, 20, 25, 20, 15, 45, 15};
  localparam int unsigned UpdPct  [NumPhases] = '{25, 10, 25, 20, 15, 30, 15};
  localparam int unsigned PoolSize = 6;

  typedef struct packed {
    lkvt_pkg::status_e         st;
    logic [lkvt_pkg::ValW-1:0] val;
  } kv_result_t;

  // Shadow copy of the table and the results the block still owes
  class kv_scoreboard;
    logic [lkvt_pkg::KeyW-1:0] keys [lkvt_pkg::Depth];
    logic [lkvt_pkg::ValW-1:0] vals [lkvt_pkg::Depth];
    int unsigned     fill;
    kv_result_t      owed [$];
    int unsigned     errors;
    int unsigned     op_seen [4];
    int unsigned     st_seen [3];
    int unsigned     peak_fill;

    function new();
      fill      = 0;
      errors    = 0;
      peak_fill = 0;
      foreach (op_seen[i]) op_seen[i] = 0;
      foreach (st_seen[i]) st_seen[i] = 0;
    endfunction

    function int unsigned pending();
      return owed.size();
    endfunction

    // Apply one accepted word to the shadow table and queue its result
    function void note_word(lkvt_pkg::opcode_e op, logic [lkvt_pkg::KeyW-1:0] k,
                            logic [lkvt_pkg::ValW-1:0] v);
      kv_result_t  r;
      int unsigned hit;
      r.st  = lkvt_pkg::StOk;
      r.val = '0;
      hit   = fill;
      // first match, front to back
      for (int unsigned i = 0; i < fill; i++) begin
        if (keys[i] == k) begin
          hit = i;
          break;
        end
      end
      if (op == lkvt_pkg::OpAppend) begin
        if (fill >= lkvt_pkg::Depth) begin
          r.st = lkvt_pkg::StFull;
        end else begin
          keys[fill] = k;
          vals[fill] = v;
          fill++;
        end
      end else if (hit >= fill) begin
        r.st = lkvt_pkg::StMissing;
      end else if (op == lkvt_pkg::OpFind) begin
        r.val = vals[hit];
      end else if (op == lkvt_pkg::OpUpdate) begin
        vals[hit] = v;
      end else begin
        // close the gap, keeping order
        for (int unsigned j = hit; j + 1 < fill; j++) begin
          keys[j] = keys[j+1];
          vals[j] = vals[j+1];
        end
        fill--;
      end
      if (fill > peak_fill) peak_fill = fill;
      op_seen[op]++;
      st_seen[r.st]++;
      owed.push_back(r);
    endfunction

    // Compare one result word with the oldest owed result
    function void check_word(logic [1:0] st, logic [lkvt_pkg::ValW-1:0] val);
      kv_result_t w;
      if (owed.size() == 0) begin
        $display("%0t: result with none owed: status %0d, value %h", $time, st, val);
        errors++;
        return;
      end
      w = owed.pop_front();
      if (st !== w.st) begin
        $display("%0t: status mismatch: expected %0d, actual %0d", $time, w.st, st);
        errors++;
      end
      if (val !== w.val) begin
        $display("%0t: found_value mismatch: expected %h, actual %h", $time, w.val, val);
        errors++;
      end
    endfunction
  endclass

  logic        clk      = 1'b0;
  logic        rst_n    = 1'b0;
  logic        s_tvalid = 1'b0;
  logic [63:0] s_tdata  = '0;
  logic [1:0]  s_tuser  = lkvt_pkg::OpAppend;
  logic        m_tready = 1'b0;
  logic        calm     = 1'b0;
  logic        s_axis_tready_o;
  logic        m_axis_tvalid_o;
  logic [31:0] m_axis_tdata_o;
  logic [1:0]  m_axis_tuser_o;

  kv_scoreboard sb;

  linear_key_value_table dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_tdata),   // [31:0] key, [63:32] value
    .s_axis_tuser_i  (s_tuser),   // [1:0] func
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_axis_tdata_o),  // [31:0] found_value
    .m_axis_tuser_o  (m_axis_tuser_o)   // [1:0] status
  );

  always #5 clk = ~clk;

  // Receiver: random stalls, none during the calm phase
  always @(posedge clk) begin
    m_tready <= calm || ($urandom_range(99) >= 14);
  end

  // Result monitor
  always @(posedge clk) begin
    if (rst_n && m_axis_tvalid_o && m_tready) begin
      sb.check_word(m_axis_tuser_o, m_axis_tdata_o);
    end
  end

  // Offer one word, with an occasional gap first, and hold it until taken
  task automatic send_word(lkvt_pkg::opcode_e op, logic [lkvt_pkg::KeyW-1:0] k,
                           logic [lkvt_pkg::ValW-1:0] v);
    int unsigned gap;
    gap = 0;
    if (!calm && $urandom_range(99) < 14) gap = $urandom_range(4, 1);
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= {v, k};
    do @(posedge clk); while (!s_axis_tready_o);
    sb.note_word(op, k, v);
  endtask

  // Hold off the sender until every owed result has come back
  task automatic drain_results();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  initial begin
    logic [lkvt_pkg::KeyW-1:0] pool [PoolSize];
    logic [lkvt_pkg::KeyW-1:0] last_key;
    logic [lkvt_pkg::KeyW-1:0] k;
    lkvt_pkg::opcode_e         op;
    int unsigned               r;
    sb = new();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Empty table: every lookup misses
    send_word(lkvt_pkg::OpFind,   32'h0000_0000, 32'h0000_0000);
    send_word(lkvt_pkg::OpUpdate, 32'h0000_0000, 32'h0000_0001);
    send_word(lkvt_pkg::OpDelete, 32'h0000_0000, 32'h0000_0000);
    // Extreme keys and values, then a duplicate key
    send_word(lkvt_pkg::OpAppend, 32'h8000_0000, 32'h7fff_ffff);
    send_word(lkvt_pkg::OpAppend, 32'h7fff_ffff, 32'h8000_0000);
    send_word(lkvt_pkg::OpAppend, 32'h0000_0000, 32'hffff_ffff);
    send_word(lkvt_pkg::OpAppend, 32'hffff_ffff, 32'h0000_0000);
    send_word(lkvt_pkg::OpAppend, 32'h0000_0000, 32'h1234_5678);
    // First match wins for find, update and delete
    send_word(lkvt_pkg::OpFind,   32'h0000_0000, 32'h0000_0000);
    send_word(lkvt_pkg::OpUpdate, 32'h0000_0000, 32'h5a5a_a5a5);
    send_word(lkvt_pkg::OpFind,   32'h0000_0000, 32'hffff_ffff);
    send_word(lkvt_pkg::OpDelete, 32'h0000_0000, 32'h0000_0000);
    send_word(lkvt_pkg::OpFind,   32'h0000_0000, 32'h0000_0000);
    send_word(lkvt_pkg::OpFind,   32'h1357_9bdf, 32'h0000_0000);
    send_word(lkvt_pkg::OpDelete, 32'h8000_0000, 32'h0000_0000);
    // Fill to the top, overflow, then take out the tail
    last_key = '0;
    while (sb.fill < lkvt_pkg::Depth) begin
      last_key = $urandom;
      send_word(lkvt_pkg::OpAppend, last_key, $urandom);
    end
    send_word(lkvt_pkg::OpAppend, 32'h2468_ace0, 32'h0000_0001);
    send_word(lkvt_pkg::OpDelete, last_key, 32'h0000_0000);
    send_word(lkvt_pkg::OpFind,   last_key, 32'h0000_0000);

    // Random phases: a small key pool keeps hits and duplicates common
    foreach (pool[i]) pool[i] = $urandom;
    for (int unsigned ph = 0; ph < NumPhases; ph++) begin
      drain_results();
      calm <= (ph == 2);
      for (int unsigned n = 0; n < PhaseLen; n++) begin
        r = $urandom_range(99);
        if (r < AppPct[ph]) op = lkvt_pkg::OpAppend;
        else if (r < AppPct[ph] + FindPct[ph]) op = lkvt_pkg::OpFind;
        else if (r < AppPct[ph] + FindPct[ph] + UpdPct[ph]) op = lkvt_pkg::OpUpdate;
        else op = lkvt_pkg::OpDelete;
        r = $urandom_range(99);
        if (op != lkvt_pkg::OpAppend && sb.fill != 0 && r < 30) begin
          k = sb.keys[$urandom_range(sb.fill - 1)];
        end else if (r < 85) begin
          k = pool[$urandom_range(PoolSize - 1)];
        end else begin
          k = $urandom;
        end
        send_word(op, k, $urandom);
      end
    end

    // Let the last results out, then allow for the deepest scan
    drain_results();
    repeat (80) @(posedge clk);
    $display("Covered %0d appends, %0d finds, %0d updates, %0d deletes.",
             sb.op_seen[lkvt_pkg::OpAppend], sb.op_seen[lkvt_pkg::OpFind],
             sb.op_seen[lkvt_pkg::OpUpdate], sb.op_seen[lkvt_pkg::OpDelete]);
    $display("Outcomes: %0d ok, %0d not found, %0d full; fill peaked at %0d of %0d.",
             sb.st_seen[lkvt_pkg::StOk], sb.st_seen[lkvt_pkg::StMissing],
             sb.st_seen[lkvt_pkg::StFull], sb.peak_fill, lkvt_pkg::Depth);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #5_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
